// ===== sv/tolerance_limited_window_smoother_core_defines.svh =====
// ----------------------------------------------------------------------------
// Smoother assertion macros
// Shared concurrent-check shorthands, clocked on i_clk, held off in reset.
// ----------------------------------------------------------------------------
`ifndef TOLERANCE_LIMITED_WINDOW_SMOOTHER_CORE_DEFINES_SVH
`define TOLERANCE_LIMITED_WINDOW_SMOOTHER_CORE_DEFINES_SVH

// same-cycle implication
`define TLWS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TLWS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/tlws_pkg.sv =====
// ----------------------------------------------------------------------------
// Smoother package
// Fixed widths, register indexes, configuration and job control types.
// ----------------------------------------------------------------------------
package tlws_pkg;

    localparam int PIX_W      = 8;
    localparam int ROW_W      = 13;
    localparam int MAX_HEIGHT = 4096;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FILTER_ENABLE   = 3'd0,
        CFG_CHROMA_BYPASS   = 3'd1,
        CFG_PLANE_IS_CHROMA = 3'd2,
        CFG_TOLERANCE       = 3'd3,
        CFG_WINDOW_RADIUS   = 3'd4,
        CFG_PLANE_WIDTH     = 3'd5,
        CFG_PLANE_HEIGHT    = 3'd6
    } t_cfg_index;

    typedef struct packed {
        logic        filter_enable;
        logic        chroma_bypass;
        logic        plane_is_chroma;
        logic [8:0]  tolerance;
        logic [1:0]  window_radius;
        logic [11:0] plane_width;
        logic [12:0] plane_height;
    } t_cfg;

    typedef struct packed {
        logic wr;
        logic emit;
        logic bypass;
        logic eor;
        logic eop;
    } t_job_ctl;

endpackage

// ===== sv/tlws_front.sv =====
// ----------------------------------------------------------------------------
// Smoother front end
// Accepts requests, tracks input and output raster positions, issues jobs.
// ----------------------------------------------------------------------------
module tlws_front #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_RADIUS = 3
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  tlws_pkg::t_cfg                       i_cfg,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_action,
    input  logic [tlws_pkg::PIX_W-1:0]           i_pixel_in,
    input  logic                                 i_q_full,
    output logic                                 o_push,
    output tlws_pkg::t_job_ctl                   o_ctl,
    output logic [tlws_pkg::ROW_W-1:0]           o_wr_row,
    output logic [$clog2(MAX_WIDTH)-1:0]         o_wr_col,
    output logic [tlws_pkg::PIX_W-1:0]           o_wr_data,
    output logic [$clog2(MAX_WIDTH)-1:0]         o_ox,
    output logic [tlws_pkg::ROW_W-1:0]           o_oy,
    output logic [tlws_pkg::ROW_W-1:0]           o_y0,
    output logic [tlws_pkg::ROW_W-1:0]           o_y1,
    output logic [$clog2(MAX_WIDTH)-1:0]         o_x0,
    output logic [$clog2(MAX_WIDTH)-1:0]         o_x1
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int CX   = WW + 1;
    localparam int PWX  = (WW > 12) ? WW : 12;
    localparam int RW   = $clog2(MAX_RADIUS + 1);
    localparam int RWD  = tlws_pkg::ROW_W;

    logic [CW-1:0]  r_in_col, r_out_col;
    logic [RWD-1:0] r_in_row, r_out_row;

    logic [PWX-1:0] pw_x;
    logic [WW-1:0]  w, w1, ic_inc, oc_inc;
    logic [RWD-1:0] h, h1;
    logic [RW-1:0]  r;
    logic           accept, wr, ready, eor, eop;
    logic [CW-1:0]  wr_col, ic_n, ox, x0, x1;
    logic [RWD-1:0] ir_n, nr_s, nr, oy, y0, y1s, y1;
    logic [CX-1:0]  nc_s, nc, x1s;

    assign pw_x = PWX'(i_cfg.plane_width);

    always_comb begin
        if (pw_x == '0) begin
            w = WW'(1);
        end else if (pw_x > PWX'(MAX_WIDTH)) begin
            w = WW'(MAX_WIDTH);
        end else begin
            w = WW'(pw_x);
        end
        if (i_cfg.plane_height == '0) begin
            h = RWD'(1);
        end else if (i_cfg.plane_height > RWD'(tlws_pkg::MAX_HEIGHT)) begin
            h = RWD'(tlws_pkg::MAX_HEIGHT);
        end else begin
            h = i_cfg.plane_height;
        end
        if (32'(i_cfg.window_radius) > MAX_RADIUS) begin
            r = RW'(MAX_RADIUS);
        end else begin
            r = RW'(i_cfg.window_radius);
        end
    end

    assign w1 = w - WW'(1);
    assign h1 = h - RWD'(1);

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;

    // write side: a pixel lands only while rows remain
    assign wr     = !i_action && (r_in_row < h);
    assign wr_col = (WW'(r_in_col) >= w) ? CW'(w1) : r_in_col;
    assign ic_inc = WW'(r_in_col) + WW'(1);

    always_comb begin
        ic_n = r_in_col;
        ir_n = r_in_row;
        if (wr) begin
            if (ic_inc >= w) begin
                ic_n = '0;
                ir_n = r_in_row + RWD'(1);
            end else begin
                ic_n = CW'(ic_inc);
            end
        end
    end

    // output is due once input passed the window's far corner
    assign nr_s  = r_out_row + RWD'(r);
    assign nr    = (nr_s > h1) ? h1 : nr_s;
    assign nc_s  = CX'(r_out_col) + CX'(r);
    assign nc    = (nc_s > CX'(w1)) ? CX'(w1) : nc_s;
    assign ready = (ir_n >= h) || (ir_n > nr) || ((ir_n == nr) && (CX'(ic_n) > nc));

    assign ox     = (WW'(r_out_col) >= w) ? CW'(w1) : r_out_col;
    assign oy     = (r_out_row >= h) ? h1 : r_out_row;
    assign oc_inc = WW'(r_out_col) + WW'(1);
    assign eor    = oc_inc >= w;
    assign eop    = eor && ((r_out_row + RWD'(1)) >= h);

    assign y0  = (oy >= RWD'(r)) ? oy - RWD'(r) : '0;
    assign y1s = oy + RWD'(r);
    assign y1  = (y1s > h1) ? h1 : y1s;
    assign x0  = (ox >= CW'(r)) ? ox - CW'(r) : '0;
    assign x1s = CX'(ox) + CX'(r);
    assign x1  = (x1s > CX'(w1)) ? CW'(w1) : CW'(x1s);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (accept) begin
            if (ready && eop) begin
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
            end else begin
                r_in_col <= ic_n;
                r_in_row <= ir_n;
                if (ready) begin
                    if (eor) begin
                        r_out_col <= '0;
                        r_out_row <= r_out_row + RWD'(1);
                    end else begin
                        r_out_col <= r_out_col + CW'(1);
                    end
                end
            end
        end
    end

    assign o_push       = accept && (wr || ready);
    assign o_ctl.wr     = wr;
    assign o_ctl.emit   = ready;
    assign o_ctl.bypass = !i_cfg.filter_enable || (i_cfg.chroma_bypass && i_cfg.plane_is_chroma);
    assign o_ctl.eor    = eor;
    assign o_ctl.eop    = eop;
    assign o_wr_row     = r_in_row;
    assign o_wr_col     = wr_col;
    assign o_wr_data    = i_pixel_in;
    assign o_ox         = ox;
    assign o_oy         = oy;
    assign o_y0         = y0;
    assign o_y1         = y1;
    assign o_x0         = x0;
    assign o_x1         = x1;

endmodule

// ===== sv/tlws_job_queue.sv =====
// ----------------------------------------------------------------------------
// Smoother job queue
// Short first-in first-out buffer between front end and back end.
// ----------------------------------------------------------------------------
module tlws_job_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_full,
    output logic              o_empty
);

    localparam int PW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CTW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PW-1:0]     r_wp, r_rp;
    logic [CTW-1:0]    r_count;

    assign o_full  = (r_count == CTW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CTW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CTW'(1);
            end
        end
    end

endmodule

// ===== sv/tlws_back.sv =====
// ----------------------------------------------------------------------------
// Smoother back end
// Row store, window scan, tolerance filter, serial divide, result register.
// ----------------------------------------------------------------------------
`include "tolerance_limited_window_smoother_core_defines.svh"

module tlws_back #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_RADIUS = 3
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [8:0]                           i_tolerance,
    input  logic                                 i_q_empty,
    output logic                                 o_pop,
    input  tlws_pkg::t_job_ctl                   i_ctl,
    input  logic [tlws_pkg::ROW_W-1:0]           i_wr_row,
    input  logic [$clog2(MAX_WIDTH)-1:0]         i_wr_col,
    input  logic [tlws_pkg::PIX_W-1:0]           i_wr_data,
    input  logic [$clog2(MAX_WIDTH)-1:0]         i_ox,
    input  logic [tlws_pkg::ROW_W-1:0]           i_oy,
    input  logic [tlws_pkg::ROW_W-1:0]           i_y0,
    input  logic [tlws_pkg::ROW_W-1:0]           i_y1,
    input  logic [$clog2(MAX_WIDTH)-1:0]         i_x0,
    input  logic [$clog2(MAX_WIDTH)-1:0]         i_x1,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [tlws_pkg::PIX_W-1:0]           o_pixel_out,
    output logic                                 o_end_of_row,
    output logic                                 o_end_of_plane
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RWD   = tlws_pkg::ROW_W;
    localparam int PXW   = tlws_pkg::PIX_W;
    localparam int ROWS  = 2 * MAX_RADIUS + 1;
    localparam int SW    = $clog2(ROWS);
    localparam int AW    = $clog2(ROWS * MAX_WIDTH);
    localparam int CNT_W = $clog2(ROWS * ROWS + 2);
    localparam int SUM_W = PXW + CNT_W;
    localparam int DW    = $clog2(SUM_W);
    localparam int MOD_S = RWD + 4;
    localparam int PRW   = RWD + MOD_S;
    localparam logic [MOD_S-1:0] MOD_K = MOD_S'((2 ** MOD_S) / ROWS);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_WMUL  = 10'b00_0000_0010,
        S_WRITE = 10'b00_0000_0100,
        S_RMUL  = 10'b00_0000_1000,
        S_CREAD = 10'b00_0001_0000,
        S_CCAP  = 10'b00_0010_0000,
        S_SCAN  = 10'b00_0100_0000,
        S_DRAIN = 10'b00_1000_0000,
        S_DIV   = 10'b01_0000_0000,
        S_OUT   = 10'b10_0000_0000
    } t_state;

    t_state             r_state;
    tlws_pkg::t_job_ctl r_ctl;
    logic [RWD-1:0]     r_wr_row, r_oy, r_y0, r_y1, r_y;
    logic [CW-1:0]      r_wr_col, r_ox, r_x0, r_x1, r_x;
    logic [PXW-1:0]     r_wr_data, r_centre, r_rdata;
    logic [PRW-1:0]     r_prod;
    logic [SW-1:0]      r_ys;
    logic               r_rv;
    logic [SUM_W-1:0]   r_sum, r_quot;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W:0]     r_rem;
    logic [DW-1:0]      r_step;
    logic               r_out_valid;
    logic [PXW-1:0]     r_pixel_out;
    logic               r_eor, r_eop;

    logic [PXW-1:0]     r_store [ROWS * MAX_WIDTH];

    logic [RWD-1:0]     mod_arg, mod_q, rem;
    logic [SW-1:0]      slot, y0_slot;
    logic [SW:0]        dd;
    logic [AW-1:0]      waddr, raddr;
    logic               mem_we, take, ge, out_load;
    logic [PXW-1:0]     diff;
    logic [SUM_W-1:0]   acc_sum;
    logic [CNT_W-1:0]   acc_cnt;
    logic [CNT_W:0]     rem_sh;

    function automatic logic [AW-1:0] store_addr(input logic [SW-1:0] s,
                                                 input logic [CW-1:0] c);
        return AW'(s) * AW'(MAX_WIDTH) + AW'(c);
    endfunction

    // row slot = row mod ROWS, reciprocal multiply then one correction
    assign mod_arg = ((r_state == S_WMUL) || (r_state == S_WRITE)) ? r_wr_row : r_oy;
    assign mod_q   = RWD'(r_prod >> MOD_S);
    assign rem     = mod_arg - RWD'(mod_q * RWD'(ROWS));
    assign slot    = (rem >= RWD'(ROWS)) ? SW'(rem - RWD'(ROWS)) : SW'(rem);

    // step back from the centre row slot to the top window row
    assign dd      = (SW + 1)'(r_oy - r_y0);
    assign y0_slot = ((SW + 1)'(slot) >= dd) ? SW'((SW + 1)'(slot) - dd)
                                             : SW'((SW + 1)'(slot) + (SW + 1)'(ROWS) - dd);

    assign mem_we = (r_state == S_WRITE);
    assign waddr  = store_addr(slot, r_wr_col);
    assign raddr  = (r_state == S_SCAN) ? store_addr(r_ys, r_x) : store_addr(slot, r_ox);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[waddr] <= r_wr_data;
        end
        r_rdata <= r_store[raddr];
    end

    assign diff    = (r_rdata > r_centre) ? r_rdata - r_centre : r_centre - r_rdata;
    assign take    = r_rv && ({1'b0, diff} < i_tolerance);
    assign acc_sum = r_sum + (take ? SUM_W'(r_rdata) : '0);
    assign acc_cnt = r_cnt + (take ? CNT_W'(1) : '0);

    assign rem_sh  = {r_rem[CNT_W-1:0], r_quot[SUM_W-1]};
    assign ge      = rem_sh >= {1'b0, r_cnt};

    assign o_pop    = (r_state == S_IDLE) && !i_q_empty;
    assign out_load = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_ctl     <= i_ctl;
                        r_wr_row  <= i_wr_row;
                        r_wr_col  <= i_wr_col;
                        r_wr_data <= i_wr_data;
                        r_ox      <= i_ox;
                        r_oy      <= i_oy;
                        r_y0      <= i_y0;
                        r_y1      <= i_y1;
                        r_x0      <= i_x0;
                        r_x1      <= i_x1;
                        r_state   <= i_ctl.wr ? S_WMUL : S_RMUL;
                    end
                end
                S_WMUL: begin
                    r_prod  <= PRW'(mod_arg) * PRW'(MOD_K);
                    r_state <= S_WRITE;
                end
                S_WRITE: begin
                    r_state <= r_ctl.emit ? S_RMUL : S_IDLE;
                end
                S_RMUL: begin
                    r_prod  <= PRW'(mod_arg) * PRW'(MOD_K);
                    r_state <= S_CREAD;
                end
                S_CREAD: begin
                    r_ys    <= y0_slot;
                    r_y     <= r_y0;
                    r_x     <= r_x0;
                    r_state <= S_CCAP;
                end
                S_CCAP: begin
                    r_centre <= r_rdata;
                    r_sum    <= SUM_W'(r_rdata);
                    r_quot   <= SUM_W'(r_rdata);
                    r_cnt    <= CNT_W'(1);
                    r_rv     <= 1'b0;
                    r_state  <= r_ctl.bypass ? S_OUT : S_SCAN;
                end
                S_SCAN: begin
                    r_sum <= acc_sum;
                    r_cnt <= acc_cnt;
                    r_rv  <= 1'b1;
                    if (r_x == r_x1) begin
                        r_x  <= r_x0;
                        r_y  <= r_y + RWD'(1);
                        r_ys <= (r_ys == SW'(ROWS - 1)) ? '0 : r_ys + SW'(1);
                        if (r_y == r_y1) begin
                            r_state <= S_DRAIN;
                        end
                    end else begin
                        r_x <= r_x + CW'(1);
                    end
                end
                S_DRAIN: begin
                    r_rv    <= 1'b0;
                    r_quot  <= acc_sum;
                    r_cnt   <= acc_cnt;
                    r_rem   <= '0;
                    r_step  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem  <= ge ? rem_sh - {1'b0, r_cnt} : rem_sh;
                    r_quot <= {r_quot[SUM_W-2:0], ge};
                    r_step <= r_step + DW'(1);
                    if (r_step == DW'(SUM_W - 1)) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_pixel_out <= r_quot[PXW-1:0];
                        r_eor       <= r_ctl.eor;
                        r_eop       <= r_ctl.eop;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pixel_out    = r_pixel_out;
    assign o_end_of_row   = r_eor;
    assign o_end_of_plane = r_eop;

    `TLWS_ASSERT_IMP(a_mod_in_range, r_state == S_WRITE, rem < RWD'(2 * ROWS), "row slot correction out of range")
    `TLWS_ASSERT_NXT(a_div_nonzero, r_state == S_DRAIN, r_cnt != '0, "divide by zero count")
    `TLWS_ASSERT_IMP(a_mean_fits, r_state == S_OUT, r_quot[SUM_W-1:PXW] == '0, "mean exceeds pixel range")

endmodule

// ===== sv/tolerance_limited_window_smoother_core.sv =====
// ----------------------------------------------------------------------------
// Tolerance-limited window smoother core
// Sigma filter over one 8-bit plane in raster order with a row store.
// ----------------------------------------------------------------------------
// Each request carries one pixel (action 0) or a flush tick (action 1) and
// yields at most one result, lagging the input by about window_radius rows;
// send flush ticks after the last pixel to drain the plane. A request that
// yields no result and writes nothing is not passed to the back end. One
// that writes a pixel without a result takes the back end through its
// multiply and write states. One with a result also takes it through
// the centre read, a scan of the N window pixels inside the plane (up to
// (2r+1)^2, 49 at radius 3) and an S-bit divide (14 bits with the default
// MAX_RADIUS). A flush tick skips the write states, a bypassed result the
// scan and divide. A full result register that is not taken adds its stall.
// Back-end time is set by the single read port of the row store, which is
// scanned one window pixel per cycle, and by the one-bit-per-cycle divider.
// A two-entry job queue lets the front end take further requests while the
// back end is busy, and the result register lets the back end finish the next
// job while a result waits. The row store needs no clearing after reset.
// Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
module tolerance_limited_window_smoother_core #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_RADIUS = 3
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tlws_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tlws_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_action,
    input  logic [7:0]                          i_pixel_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [7:0]                          o_pixel_out,
    output logic                                o_end_of_row,
    output logic                                o_end_of_plane
);

    localparam int CW      = $clog2(MAX_WIDTH);
    localparam int RWD     = tlws_pkg::ROW_W;
    localparam int PXW     = tlws_pkg::PIX_W;
    localparam int Q_DEPTH = 2;
    localparam int JOB_W   = $bits(tlws_pkg::t_job_ctl) + 4 * RWD + 4 * CW + PXW;

    tlws_pkg::t_cfg     r_cfg;
    tlws_pkg::t_job_ctl f_ctl, q_ctl;
    logic               f_push, q_full, q_empty, b_pop;
    logic [RWD-1:0]     f_wr_row, f_oy, f_y0, f_y1, q_wr_row, q_oy, q_y0, q_y1;
    logic [CW-1:0]      f_wr_col, f_ox, f_x0, f_x1, q_wr_col, q_ox, q_x0, q_x1;
    logic [PXW-1:0]     f_wr_data, q_wr_data;
    logic [JOB_W-1:0]   q_din, q_dout;

    // Configuration: always ready, write decoded by register index
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.filter_enable   <= 1'b0;
            r_cfg.chroma_bypass   <= 1'b1;
            r_cfg.plane_is_chroma <= 1'b0;
            r_cfg.tolerance       <= 9'd8;
            r_cfg.window_radius   <= 2'd3;
            r_cfg.plane_width     <= 12'd1920;
            r_cfg.plane_height    <= 13'd1080;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (tlws_pkg::t_cfg_index'(i_cfg_index))
                tlws_pkg::CFG_FILTER_ENABLE:   r_cfg.filter_enable   <= i_cfg_data[0];
                tlws_pkg::CFG_CHROMA_BYPASS:   r_cfg.chroma_bypass   <= i_cfg_data[0];
                tlws_pkg::CFG_PLANE_IS_CHROMA: r_cfg.plane_is_chroma <= i_cfg_data[0];
                tlws_pkg::CFG_TOLERANCE:       r_cfg.tolerance       <= i_cfg_data[8:0];
                tlws_pkg::CFG_WINDOW_RADIUS:   r_cfg.window_radius   <= i_cfg_data[1:0];
                tlws_pkg::CFG_PLANE_WIDTH:     r_cfg.plane_width     <= i_cfg_data[11:0];
                tlws_pkg::CFG_PLANE_HEIGHT:    r_cfg.plane_height    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Front end: accept, advance raster counters, decide which requests emit
    tlws_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_action   (i_action),
        .i_pixel_in (i_pixel_in),
        .i_q_full   (q_full),
        .o_push     (f_push),
        .o_ctl      (f_ctl),
        .o_wr_row   (f_wr_row),
        .o_wr_col   (f_wr_col),
        .o_wr_data  (f_wr_data),
        .o_ox       (f_ox),
        .o_oy       (f_oy),
        .o_y0       (f_y0),
        .o_y1       (f_y1),
        .o_x0       (f_x0),
        .o_x1       (f_x1)
    );

    // Pack each job; the back end applies the store write before its reads,
    // so the queue keeps the row store in request order
    assign q_din = {f_ctl, f_wr_row, f_wr_col, f_wr_data, f_ox, f_oy,
                    f_y0, f_y1, f_x0, f_x1};
    assign {q_ctl, q_wr_row, q_wr_col, q_wr_data, q_ox, q_oy,
            q_y0, q_y1, q_x0, q_x1} = q_dout;

    tlws_job_queue #(
        .DATA_W (JOB_W),
        .DEPTH  (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (q_din),
        .i_pop   (b_pop),
        .o_data  (q_dout),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // Back end: row store, window scan, divide and result register
    tlws_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_tolerance    (r_cfg.tolerance),
        .i_q_empty      (q_empty),
        .o_pop          (b_pop),
        .i_ctl          (q_ctl),
        .i_wr_row       (q_wr_row),
        .i_wr_col       (q_wr_col),
        .i_wr_data      (q_wr_data),
        .i_ox           (q_ox),
        .i_oy           (q_oy),
        .i_y0           (q_y0),
        .i_y1           (q_y1),
        .i_x0           (q_x0),
        .i_x1           (q_x1),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_pixel_out    (o_pixel_out),
        .o_end_of_row   (o_end_of_row),
        .o_end_of_plane (o_end_of_plane)
    );

endmodule

// ===== tb/tb_tolerance_limited_window_smoother_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Smoother core testbench
// Drives whole planes of pixels and flush ticks through the core under a
// range of register settings and handshake pressure. Every result is checked
// field by field against a behavioural sigma filter kept alongside the core or a directed table.
// ----------------------------------------------------------------------------
module tb_tolerance_limited_window_smoother_core;

    localparam int MAXW        = 2048;
    localparam int MAXR        = 3;
    localparam int STORE_ROWS  = 2 * MAXR + 1;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int PIXEL_GOAL  = 1450;

    typedef enum logic [1:0] {ROW_PREDICT, ROW_RESULT, ROW_QUIET} t_row_kind;

    typedef struct packed {
        logic [7:0] pix;
        logic       eor;
        logic       eop;
    } t_smoothed;

    typedef struct packed {
        t_row_kind  kind;
        logic       act;
        logic [7:0] pix;
        t_smoothed  res;
    } t_stim_row;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [tlws_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [tlws_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                            i_in_valid = 1'b0;
    logic                            o_in_ready;
    logic                            i_action = 1'b0;
    logic [7:0]                      i_pixel_in = '0;
    logic                            o_out_valid;
    logic                            i_out_ready = 1'b0;
    logic [7:0]                      o_pixel_out;
    logic                            o_end_of_row;
    logic                            o_end_of_plane;

    tolerance_limited_window_smoother_core dut (.*);

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Filter shadow: register copy, row store and the four raster counters
    // ------------------------------------------------------------------
    tlws_pkg::t_cfg shadow_cfg;
    logic [7:0] shadow_rows [STORE_ROWS*MAXW];
    int         in_col, in_row, out_col, out_row;

    t_smoothed  pending_pixels [$];
    int         errors = 0;
    int         results_seen = 0;
    int         pixels_sent = 0;
    int         ticks_sent = 0;
    int         cycles = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;

    function automatic int clamp_w();
        int w = shadow_cfg.plane_width;
        if (w < 1) w = 1;
        if (w > MAXW) w = MAXW;
        return w;
    endfunction

    function automatic int clamp_h();
        int h = shadow_cfg.plane_height;
        if (h < 1) h = 1;
        if (h > tlws_pkg::MAX_HEIGHT) h = tlws_pkg::MAX_HEIGHT;
        return h;
    endfunction

    function automatic int clamp_r();
        return (shadow_cfg.window_radius > MAXR) ? MAXR : int'(shadow_cfg.window_radius);
    endfunction

    function automatic logic [7:0] row_read(int row, int col);
        if (col >= MAXW) col = MAXW - 1;
        return shadow_rows[(row % STORE_ROWS) * MAXW + col];
    endfunction

    function automatic bit plane_idle();
        return in_col == 0 && in_row == 0 && out_col == 0 && out_row == 0;
    endfunction

    // Advance the shadow by one request; report the result it yields, if any.
    function automatic bit smooth_step(input logic act, input logic [7:0] px,
                                       output t_smoothed res);
        int w, h, r, nr, nc, ox, oy, y0, y1, x0, x1, sum, cnt, d;
        logic [7:0] centre, v;
        bit ready;
        w = clamp_w();
        h = clamp_h();
        r = clamp_r();
        res = '0;
        if (!act && in_row < h) begin
            shadow_rows[(in_row % STORE_ROWS) * MAXW + ((in_col >= w) ? w - 1 : in_col)] = px;
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
            end
        end
        if (in_row >= h) begin
            ready = 1'b1;
        end else begin
            nr = (out_row + r > h - 1) ? h - 1 : out_row + r;
            nc = (out_col + r > w - 1) ? w - 1 : out_col + r;
            ready = (in_row > nr) || (in_row == nr && in_col > nc);
        end
        if (!ready) return 1'b0;

        ox = (out_col >= w) ? w - 1 : out_col;
        oy = (out_row >= h) ? h - 1 : out_row;
        centre = row_read(oy, ox);
        res.pix = centre;
        if (shadow_cfg.filter_enable &&
            !(shadow_cfg.chroma_bypass && shadow_cfg.plane_is_chroma)) begin
            y0 = (oy >= r) ? oy - r : 0;
            y1 = (oy + r > h - 1) ? h - 1 : oy + r;
            x0 = (ox >= r) ? ox - r : 0;
            x1 = (ox + r > w - 1) ? w - 1 : ox + r;
            sum = centre;
            cnt = 1;
            for (int y = y0; y <= y1; y++) begin
                for (int x = x0; x <= x1; x++) begin
                    v = row_read(y, x);
                    d = (v > centre) ? v - centre : centre - v;
                    if (d < shadow_cfg.tolerance) begin
                        sum += v;
                        cnt++;
                    end
                end
            end
            res.pix = 8'(sum / cnt);
        end
        res.eor = (out_col + 1 >= w);
        res.eop = res.eor && (out_row + 1 >= h);
        if (res.eop) begin
            in_col = 0; in_row = 0; out_col = 0; out_row = 0;
        end else if (res.eor) begin
            out_col = 0;
            out_row++;
        end else begin
            out_col++;
        end
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    task automatic idle_gap();
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
            @(posedge i_clk);
        end
    endtask

    // Send one request and return the shadow's prediction for it.
    task automatic send_request(input logic act, input logic [7:0] px,
                                output bit got, output t_smoothed res);
        idle_gap();
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_pixel_in <= px;
        do @(posedge i_clk); while (!o_in_ready);
        got = smooth_step(act, px, res);
        if (act) ticks_sent++;
        else pixels_sent++;
    endtask

    task automatic push_request(input logic act, input logic [7:0] px);
        bit got;
        t_smoothed res;
        send_request(act, px, got, res);
        if (got) pending_pixels.push_back(res);
    endtask

    // Hold off until the core has delivered everything and drained its queue.
    task automatic drain_quiet();
        i_in_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    task automatic write_reg(input tlws_pkg::t_cfg_index idx, input int val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val[tlws_pkg::CFG_DATA_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        case (idx)
            tlws_pkg::CFG_FILTER_ENABLE:   shadow_cfg.filter_enable   = val[0];
            tlws_pkg::CFG_CHROMA_BYPASS:   shadow_cfg.chroma_bypass   = val[0];
            tlws_pkg::CFG_PLANE_IS_CHROMA: shadow_cfg.plane_is_chroma = val[0];
            tlws_pkg::CFG_TOLERANCE:       shadow_cfg.tolerance       = val[8:0];
            tlws_pkg::CFG_WINDOW_RADIUS:   shadow_cfg.window_radius   = val[1:0];
            tlws_pkg::CFG_PLANE_WIDTH:     shadow_cfg.plane_width     = val[11:0];
            tlws_pkg::CFG_PLANE_HEIGHT:    shadow_cfg.plane_height    = val[12:0];
            default: ;
        endcase
    endtask

    // Send one well-formed plane with random content, then drain it.
    task automatic run_plane(input bit pause_midway);
        int npix, base, spread;
        npix   = clamp_w() * clamp_h();
        base   = $urandom_range(255);
        spread = $urandom_range(3) == 0 ? 255 : $urandom_range(24);
        for (int i = 0; i < npix; i++) begin
            if ($urandom_range(99) < 8) push_request(1'b1, 8'($urandom_range(255)));
            if (pause_midway && i == npix / 2) drain_quiet();
            if ($urandom_range(99) < 12)
                push_request(1'b0, 8'($urandom_range(255)));
            else
                push_request(1'b0, 8'(base + $urandom_range(2 * spread) - spread));
        end
        // Drain: mostly flush ticks, sometimes a stray pixel that gets dropped
        while (!plane_idle())
            push_request($urandom_range(99) >= 15, 8'($urandom_range(255)));
    endtask

    // ------------------------------------------------------------------
    // Result side: check every result, stall at random
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_smoothed want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (pending_pixels.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result pix=%0d eor=%0b eop=%0b", $time,
                             o_pixel_out, o_end_of_row, o_end_of_plane);
                end else begin
                    want = pending_pixels.pop_front();
                    if (o_pixel_out !== want.pix) begin
                        errors++;
                        $display("%0t: pixel_out expected %0d got %0d", $time,
                                 want.pix, o_pixel_out);
                    end
                    if (o_end_of_row !== want.eor) begin
                        errors++;
                        $display("%0t: end_of_row expected %0b got %0b", $time,
                                 want.eor, o_end_of_row);
                    end
                    if (o_end_of_plane !== want.eop) begin
                        errors++;
                        $display("%0t: end_of_plane expected %0b got %0b", $time,
                                 want.eop, o_end_of_plane);
                    end
                end
            end
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: run stalled, %0d results still awaited", $time,
                     pending_pixels.size());
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Directed table: bypass 2x2 at radius 0 reads straight off the input;
    // the rest covers zero tolerance, a dropped pixel and an idle flush.
    // ------------------------------------------------------------------
    t_stim_row stim_rows [17];
    localparam int SEG_B = 5;

    initial begin
        bit got;
        t_smoothed res;
        int phase, tol_pick;

        stim_rows[0]  = '{ROW_RESULT, 1'b0, 8'h00, '{8'h00, 1'b0, 1'b0}};
        stim_rows[1]  = '{ROW_RESULT, 1'b0, 8'hFF, '{8'hFF, 1'b1, 1'b0}};
        stim_rows[2]  = '{ROW_RESULT, 1'b0, 8'h55, '{8'h55, 1'b0, 1'b0}};
        stim_rows[3]  = '{ROW_RESULT, 1'b0, 8'hAA, '{8'hAA, 1'b1, 1'b1}};
        stim_rows[4]  = '{ROW_QUIET,  1'b1, 8'h00, '0};
        stim_rows[5]  = '{ROW_PREDICT, 1'b0, 8'h10, '0};
        stim_rows[6]  = '{ROW_PREDICT, 1'b0, 8'hF0, '0};
        stim_rows[7]  = '{ROW_PREDICT, 1'b0, 8'h12, '0};
        stim_rows[8]  = '{ROW_PREDICT, 1'b0, 8'h00, '0};
        stim_rows[9]  = '{ROW_PREDICT, 1'b0, 8'hFF, '0};
        stim_rows[10] = '{ROW_PREDICT, 1'b0, 8'h11, '0};
        stim_rows[11] = '{ROW_PREDICT, 1'b0, 8'h77, '0};  // past plane end: dropped
        for (int i = 12; i < 17; i++) stim_rows[i] = '{ROW_PREDICT, 1'b1, 8'h00, '0};

        shadow_cfg = '{1'b0, 1'b1, 1'b0, 9'd8, 2'd3, 12'd1920, 13'd1080};
        in_col = 0; in_row = 0; out_col = 0; out_row = 0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_reg(tlws_pkg::CFG_FILTER_ENABLE, 0);
        write_reg(tlws_pkg::CFG_WINDOW_RADIUS, 0);
        write_reg(tlws_pkg::CFG_PLANE_WIDTH, 2);
        write_reg(tlws_pkg::CFG_PLANE_HEIGHT, 2);
        for (int i = 0; i < 17; i++) begin
            if (i == SEG_B) begin
                drain_quiet();
                write_reg(tlws_pkg::CFG_FILTER_ENABLE, 1);
                write_reg(tlws_pkg::CFG_CHROMA_BYPASS, 0);
                write_reg(tlws_pkg::CFG_TOLERANCE, 0);
                write_reg(tlws_pkg::CFG_WINDOW_RADIUS, 3);
                write_reg(tlws_pkg::CFG_PLANE_WIDTH, 3);
                write_reg(tlws_pkg::CFG_PLANE_HEIGHT, 2);
            end
            send_request(stim_rows[i].act, stim_rows[i].pix, got, res);
            case (stim_rows[i].kind)
                ROW_RESULT: pending_pixels.push_back(stim_rows[i].res);
                ROW_QUIET: if (got) begin
                    errors++;
                    $display("%0t: shadow predicts a result on an idle flush", $time);
                end
                default: if (got) pending_pixels.push_back(res);
            endcase
        end
        drain_quiet();

        // Random phases: cycle through idling modes, fresh registers each time
        phase = 0;
        while (pixels_sent < PIXEL_GOAL) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            write_reg(tlws_pkg::CFG_FILTER_ENABLE, $urandom_range(99) < 80);
            write_reg(tlws_pkg::CFG_CHROMA_BYPASS, $urandom_range(1));
            write_reg(tlws_pkg::CFG_PLANE_IS_CHROMA, $urandom_range(1));
            tol_pick = $urandom_range(7);
            write_reg(tlws_pkg::CFG_TOLERANCE, tol_pick == 0 ? 0 : tol_pick == 1 ? 511 :
                                               tol_pick == 2 ? 256 : tol_pick == 3 ? 257 :
                                               $urandom_range(40));
            write_reg(tlws_pkg::CFG_WINDOW_RADIUS, $urandom_range(3));
            // Zero geometry acts as one; now and then a longer row
            write_reg(tlws_pkg::CFG_PLANE_WIDTH, $urandom_range(15) == 0 ? 0 :
                                                 $urandom_range(20) == 0 ? $urandom_range(24, 40)
                                                                         : $urandom_range(1, 14));
            write_reg(tlws_pkg::CFG_PLANE_HEIGHT,
                      $urandom_range(15) == 0 ? 0 : $urandom_range(1, 9));
            repeat ($urandom_range(1, 2)) run_plane(phase == 3);
            drain_quiet();
            phase++;
        end
        // Top register bits: write widest allowed width and over-range height, then run a tiny plane
        write_reg(tlws_pkg::CFG_PLANE_WIDTH, 4095);
        write_reg(tlws_pkg::CFG_PLANE_HEIGHT, 8191);
        write_reg(tlws_pkg::CFG_PLANE_WIDTH, 3);
        write_reg(tlws_pkg::CFG_PLANE_HEIGHT, 2);
        run_plane(1'b0);
        drain_quiet();

        $display("Covered %0d pixels and %0d flush ticks over %0d register phases;",
                 pixels_sent, ticks_sent, phase);
        $display("checked %0d results with %0d mismatches.", results_seen, errors);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
